@@ hw/rtl/tagged_stack_bytecode_core_assert.svh @@
// Assertion macros for the RTL of the bytecode core.
// Expects signals named clock and reset in the scope of each use.
`ifndef TAGGED_STACK_BYTECODE_CORE_ASSERT_SVH
`define TAGGED_STACK_BYTECODE_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define TSBC_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
`define TSBC_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define TSBC_ASSERT_IMP(lbl, ante, cons)
`define TSBC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ hw/rtl/tsbc_pkg.sv @@
// Package for the tagged stack bytecode core: sizes, word types, codes.
// No dependencies.
`default_nettype none
package tsbc_pkg;
   localparam int VALUE_DEPTH = 64;
   localparam int ARG_DEPTH   = 64;
   localparam int FRAME_DEPTH = 32;
   localparam int VALUE_WIDTH = 32;
   localparam int LINE_WIDTH  = 16;

   localparam int VAW = $clog2(VALUE_DEPTH);
   localparam int VPW = $clog2(VALUE_DEPTH + 1);
   localparam int AAW = $clog2(ARG_DEPTH);
   localparam int APW = $clog2(ARG_DEPTH + 1);
   localparam int FAW = $clog2(FRAME_DEPTH);
   localparam int FPW = $clog2(FRAME_DEPTH + 1);
   localparam int ENTRY_W = VALUE_WIDTH + 1;
   localparam int FRAME_W = LINE_WIDTH + APW;
   localparam int SUM_W   = ((APW > VPW) ? APW : VPW) + 1;
   localparam int ALU_W   = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;
   localparam logic [31:0] MAX_STEPS_RESET = 32'd1000000;

   localparam logic [3:0] OP_POPJZ   = 4'd0;
   localparam logic [3:0] OP_DEC     = 4'd1;
   localparam logic [3:0] OP_CONST   = 4'd2;
   localparam logic [3:0] OP_JNZ     = 4'd3;
   localparam logic [3:0] OP_COPY    = 4'd4;
   localparam logic [3:0] OP_LOAD    = 4'd5;
   localparam logic [3:0] OP_CALL    = 4'd6;
   localparam logic [3:0] OP_MARK    = 4'd7;
   localparam logic [3:0] OP_RET     = 4'd8;
   localparam logic [3:0] OP_INC     = 4'd9;
   localparam logic [3:0] OP_POP     = 4'd10;

   localparam logic [1:0] FAULT_NONE  = 2'd0;
   localparam logic [1:0] FAULT_STEP  = 2'd1;
   localparam logic [1:0] FAULT_STACK = 2'd2;

   localparam logic [1:0] ALU_GE      = 2'd0;
   localparam logic [1:0] ALU_SAT_INC = 2'd1;
   localparam logic [1:0] ALU_SAT_DEC = 2'd2;

   typedef struct packed {
      logic [3:0]  op;
      logic        halt_request;
      logic [31:0] argument;
   } req_word_type;

   typedef struct packed {
      logic [15:0] next_line;
      logic        halted;
      logic [31:0] result_value;
      logic [1:0]  fault;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0]       fn;
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [ALU_W-1:0] r;
      logic             flag;
   } alu_rsp_type;
endpackage
`default_nettype wire

@@ hw/rtl/tagged_stack_bytecode_core.sv @@
// Tagged stack bytecode core. One req word is one instruction (op, halt
// request, argument); one rsp word comes back for each: next line, halted
// flag with top of stack, fault code. The core holds a tagged value stack,
// an argument stack and a frame stack in RAMs with registered reads, and a
// sequencer that drives one shared compare/step unit. Steps, from the
// accepting edge to the load of the rsp register: push constant, push
// marker, unused ops, pop at depth 0 and faults found at the check go
// through check and finish; the other ops through check, execute, finish;
// call walks down over the entries above the nearest call marker (one
// value RAM read and one argument RAM write per entry), and a call that
// finds no marker walks the whole stack; pop at depth a does one read and
// one write per moved entry. The value RAM port sets this pace. Finish
// waits on a stalled rsp register.
// req_stall is low only while the sequencer idles; the rsp register lets
// a new word in while the last result waits. A halt or any fault clears
// the pointers, the line and the step counter. The step limit comes from
// the one csr register (reset 1000000); write it only while idle.
// Depends on tsbc_pkg, tsbc_ram, tsbc_alu and the assertion header.
`default_nettype none
`include "tagged_stack_bytecode_core_assert.svh"
module tagged_stack_bytecode_core (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  tsbc_pkg::req_word_type      req_word,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output tsbc_pkg::rsp_word_type      rsp_word,
   input  wire logic                   csr_write_enable,
   input  wire logic [31:0]            csr_write_data
);
   import tsbc_pkg::*;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_CHECK   = 3'd1;
   localparam logic [2:0] S_EXEC    = 3'd2;
   localparam logic [2:0] S_SCAN    = 3'd3;
   localparam logic [2:0] S_SCAN_W  = 3'd4;
   localparam logic [2:0] S_SHIFT   = 3'd5;
   localparam logic [2:0] S_SHIFT_W = 3'd6;
   localparam logic [2:0] S_FIN     = 3'd7;

   // control state
   logic [2:0]            state_ff, state_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VPW-1:0]        vt_ff, vt_in;
   logic [APW-1:0]        at_ff, at_in;
   logic [FPW-1:0]        ft_ff, ft_in;
   logic [LINE_WIDTH-1:0] line_ff, line_in;
   logic [31:0]           step_ff, step_in;
   logic [31:0]           max_ff, max_in;

   // per-word working registers
   logic [3:0]             op_ff, op_in;
   logic                   halt_ff, halt_in;
   logic [31:0]            arg_ff, arg_in;
   logic [VPW-1:0]         idx_ff, idx_in;
   logic [VAW-1:0]         addr_ff, addr_in;
   logic [LINE_WIDTH-1:0]  next_ff, next_in;
   logic                   halted_ff, halted_in;
   logic [31:0]            result_ff, result_in;
   logic                   flt2_ff, flt2_in;
   rsp_word_type           rsp_ff, rsp_in;

   // RAM ports
   logic               v_we, a_we, f_we;
   logic [VAW-1:0]     v_waddr, v_raddr;
   logic [ENTRY_W-1:0] v_wdata, v_rdata;
   logic [AAW-1:0]     a_waddr, a_raddr;
   logic [VALUE_WIDTH-1:0] a_wdata, a_rdata;
   logic [FAW-1:0]     f_waddr, f_raddr;
   logic [FRAME_W-1:0] f_wdata, f_rdata;

   alu_req_type alu_req;
   alu_rsp_type alu_rsp;

   logic                  out_free;
   logic [VPW-1:0]        argn_v;
   logic [APW-1:0]        argn_a;
   logic [SUM_W-1:0]      arg_sum;
   logic [APW-1:0]        f_cnt;
   logic [LINE_WIDTH-1:0] f_line;
   logic [31:0]           step_next;
   logic [1:0]            flt;

   tsbc_ram #(.WIDTH(ENTRY_W), .DEPTH(VALUE_DEPTH)) u_value_ram (
      .clock(clock), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
      .raddr(v_raddr), .rdata(v_rdata)
   );
   tsbc_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(ARG_DEPTH)) u_arg_ram (
      .clock(clock), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
      .raddr(a_raddr), .rdata(a_rdata)
   );
   tsbc_ram #(.WIDTH(FRAME_W), .DEPTH(FRAME_DEPTH)) u_frame_ram (
      .clock(clock), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
      .raddr(f_raddr), .rdata(f_rdata)
   );

   tsbc_alu u_alu (.req(alu_req), .rsp(alu_rsp));

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   // depth arguments are only used once known to be below the pointer
   assign argn_v    = arg_ff[VPW-1:0];
   assign argn_a    = arg_ff[APW-1:0];
   assign arg_sum   = SUM_W'(at_ff) + SUM_W'(idx_ff);
   assign f_cnt     = f_rdata[APW-1:0];
   assign f_line    = f_rdata[FRAME_W-1:APW];
   assign step_next = step_ff + 32'd1;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      vt_in        = vt_ff;
      at_in        = at_ff;
      ft_in        = ft_ff;
      line_in      = line_ff;
      step_in      = step_ff;
      max_in       = csr_write_enable ? csr_write_data : max_ff;
      op_in        = op_ff;
      halt_in      = halt_ff;
      arg_in       = arg_ff;
      idx_in       = idx_ff;
      addr_in      = addr_ff;
      next_in      = next_ff;
      halted_in    = halted_ff;
      result_in    = result_ff;
      flt2_in      = flt2_ff;
      rsp_in       = rsp_ff;
      flt          = FAULT_NONE;

      v_we    = 1'b0;
      v_waddr = VAW'(vt_ff);
      v_wdata = v_rdata;
      v_raddr = VAW'(vt_ff - VPW'(1));
      a_we    = 1'b0;
      a_waddr = AAW'(arg_sum);
      a_wdata = v_rdata[VALUE_WIDTH-1:0];
      a_raddr = AAW'(at_ff - APW'(1) - argn_a);
      f_we    = 1'b0;
      f_waddr = FAW'(ft_ff);
      f_wdata = {line_ff, APW'(idx_ff)};
      f_raddr = FAW'(ft_ff - FPW'(1));

      alu_req.fn = ALU_GE;
      alu_req.a  = ALU_W'(arg_ff);
      alu_req.b  = (op_ff == OP_LOAD) ? ALU_W'(at_ff) : ALU_W'(vt_ff);

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in     = req_word.op;
               halt_in   = req_word.halt_request;
               arg_in    = req_word.argument;
               next_in   = line_ff + LINE_WIDTH'(1);
               halted_in = 1'b0;
               result_in = '0;
               flt2_in   = 1'b0;
               idx_in    = '0;
               state_in  = S_CHECK;
            end
         end
         S_CHECK: begin
            // stack checks; reads for the execute step are issued here
            state_in = S_EXEC;
            addr_in  = VAW'(vt_ff - VPW'(1) - argn_v);
            if (halt_ff) begin
               if (vt_ff == '0) begin
                  flt2_in  = 1'b1;
                  state_in = S_FIN;
               end
            end else begin
               case (op_ff)
                  OP_POPJZ, OP_JNZ: begin
                     if (vt_ff == '0) begin
                        flt2_in  = 1'b1;
                        state_in = S_FIN;
                     end
                  end
                  OP_DEC, OP_INC: begin
                     v_raddr = addr_in;
                     if (alu_rsp.flag) begin
                        flt2_in  = 1'b1;
                        state_in = S_FIN;
                     end
                  end
                  OP_CONST, OP_MARK: begin
                     state_in = S_FIN;
                     if (vt_ff == VPW'(VALUE_DEPTH)) begin
                        flt2_in = 1'b1;
                     end else begin
                        v_we = 1'b1;
                        if (op_ff == OP_CONST) begin
                           v_wdata = {1'b0, VALUE_WIDTH'(arg_ff)};
                        end else begin
                           v_wdata = {1'b1, VALUE_WIDTH'(arg_ff[LINE_WIDTH-1:0])};
                        end
                        vt_in = vt_ff + VPW'(1);
                     end
                  end
                  OP_COPY: begin
                     v_raddr = addr_in;
                     if (alu_rsp.flag || vt_ff == VPW'(VALUE_DEPTH)) begin
                        flt2_in  = 1'b1;
                        state_in = S_FIN;
                     end
                  end
                  OP_LOAD: begin
                     if (alu_rsp.flag || vt_ff == VPW'(VALUE_DEPTH)) begin
                        flt2_in  = 1'b1;
                        state_in = S_FIN;
                     end
                  end
                  OP_CALL: begin
                     if (ft_ff == FPW'(FRAME_DEPTH)) begin
                        flt2_in  = 1'b1;
                        state_in = S_FIN;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  OP_RET: begin
                     if (ft_ff == '0) begin
                        flt2_in  = 1'b1;
                        state_in = S_FIN;
                     end
                  end
                  OP_POP: begin
                     if (alu_rsp.flag) begin
                        flt2_in  = 1'b1;
                        state_in = S_FIN;
                     end else if (argn_v == '0) begin
                        vt_in    = vt_ff - VPW'(1);
                        state_in = S_FIN;
                     end else begin
                        idx_in   = vt_ff - argn_v;
                        state_in = S_SHIFT;
                     end
                  end
                  default: begin
                     state_in = S_FIN;
                  end
               endcase
            end
         end
         S_EXEC: begin
            state_in = S_FIN;
            if (halt_ff) begin
               halted_in = 1'b1;
               result_in = 32'(v_rdata[VALUE_WIDTH-1:0]);
            end else begin
               case (op_ff)
                  OP_POPJZ: begin
                     vt_in = vt_ff - VPW'(1);
                     if (v_rdata == '0) begin
                        next_in = LINE_WIDTH'(arg_ff);
                     end
                  end
                  OP_JNZ: begin
                     if (v_rdata != '0) begin
                        next_in = LINE_WIDTH'(arg_ff);
                     end
                  end
                  OP_DEC, OP_INC: begin
                     alu_req.fn = (op_ff == OP_INC) ? ALU_SAT_INC : ALU_SAT_DEC;
                     alu_req.a  = ALU_W'(v_rdata[VALUE_WIDTH-1:0]);
                     v_we       = 1'b1;
                     v_waddr    = addr_ff;
                     v_wdata    = {v_rdata[VALUE_WIDTH], alu_rsp.r[VALUE_WIDTH-1:0]};
                  end
                  OP_COPY: begin
                     v_we  = 1'b1;
                     vt_in = vt_ff + VPW'(1);
                  end
                  OP_LOAD: begin
                     v_we    = 1'b1;
                     v_wdata = {1'b0, a_rdata};
                     vt_in   = vt_ff + VPW'(1);
                  end
                  OP_RET: begin
                     if (f_cnt > at_ff) begin
                        flt2_in = 1'b1;
                     end else begin
                        ft_in   = ft_ff - FPW'(1);
                        at_in   = at_ff - f_cnt;
                        next_in = f_line + LINE_WIDTH'(1);
                     end
                  end
                  default: begin
                     state_in = S_FIN;
                  end
               endcase
            end
         end
         S_SCAN: begin
            // walk down from the top looking for a call marker
            v_raddr = VAW'(vt_ff - VPW'(1) - idx_ff);
            if (idx_ff == vt_ff) begin
               flt2_in  = 1'b1;
               state_in = S_FIN;
            end else begin
               state_in = S_SCAN_W;
            end
         end
         S_SCAN_W: begin
            if (v_rdata[VALUE_WIDTH]) begin
               state_in = S_FIN;
               if (arg_sum > SUM_W'(ARG_DEPTH)) begin
                  flt2_in = 1'b1;
               end else begin
                  vt_in   = vt_ff - idx_ff - VPW'(1);
                  at_in   = APW'(arg_sum);
                  f_we    = 1'b1;
                  ft_in   = ft_ff + FPW'(1);
                  next_in = LINE_WIDTH'(v_rdata[VALUE_WIDTH-1:0]);
               end
            end else begin
               // move as we go; entries above the pointer are dead on a fault
               a_we     = arg_sum < SUM_W'(ARG_DEPTH);
               idx_in   = idx_ff + VPW'(1);
               state_in = S_SCAN;
            end
         end
         S_SHIFT: begin
            v_raddr  = VAW'(idx_ff);
            state_in = S_SHIFT_W;
         end
         S_SHIFT_W: begin
            v_we    = 1'b1;
            v_waddr = VAW'(idx_ff - VPW'(1));
            if (idx_ff == vt_ff - VPW'(1)) begin
               vt_in    = vt_ff - VPW'(1);
               state_in = S_FIN;
            end else begin
               idx_in   = idx_ff + VPW'(1);
               state_in = S_SHIFT;
            end
         end
         S_FIN: begin
            alu_req.fn = ALU_GE;
            alu_req.a  = ALU_W'(step_next);
            alu_req.b  = ALU_W'(max_ff);
            if (out_free) begin
               if (flt2_ff) begin
                  flt = FAULT_STACK;
               end else if (!halt_ff) begin
                  step_in = step_next;
                  if (alu_rsp.flag) begin
                     flt = FAULT_STEP;
                  end
               end
               rsp_in.halted       = halted_ff;
               rsp_in.result_value = halted_ff ? result_ff : 32'd0;
               rsp_in.fault        = flt;
               if (halted_ff || flt != FAULT_NONE) begin
                  rsp_in.next_line = '0;
                  vt_in   = '0;
                  at_in   = '0;
                  ft_in   = '0;
                  line_in = '0;
                  step_in = '0;
               end else begin
                  rsp_in.next_line = 16'(next_ff);
                  line_in          = next_ff;
               end
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         vt_ff        <= '0;
         at_ff        <= '0;
         ft_ff        <= '0;
         line_ff      <= '0;
         step_ff      <= '0;
         max_ff       <= MAX_STEPS_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         vt_ff        <= vt_in;
         at_ff        <= at_in;
         ft_ff        <= ft_in;
         line_ff      <= line_in;
         step_ff      <= step_in;
         max_ff       <= max_in;
      end
      op_ff     <= op_in;
      halt_ff   <= halt_in;
      arg_ff    <= arg_in;
      idx_ff    <= idx_in;
      addr_ff   <= addr_in;
      next_ff   <= next_in;
      halted_ff <= halted_in;
      result_ff <= result_in;
      flt2_ff   <= flt2_in;
      rsp_ff    <= rsp_in;
   end

   `TSBC_ASSERT_IMP(a_vt_bound, 1'b1, vt_ff <= VPW'(VALUE_DEPTH))
   `TSBC_ASSERT_IMP(a_at_bound, 1'b1, at_ff <= APW'(ARG_DEPTH))
   `TSBC_ASSERT_IMP(a_ft_bound, 1'b1, ft_ff <= FPW'(FRAME_DEPTH))
   `TSBC_ASSERT_IMP(a_halt_clean, rsp_valid_ff && rsp_ff.halted, rsp_ff.fault == FAULT_NONE && rsp_ff.next_line == '0)
   `TSBC_ASSERT_NXT(a_accept_check, req_valid && !req_stall, state_ff == S_CHECK)
endmodule
`default_nettype wire

@@ hw/rtl/tsbc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module tsbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

@@ hw/rtl/tsbc_alu.sv @@
// Shared compare / saturating step unit of the bytecode core.
// Uses tsbc_pkg.
`default_nettype none
module tsbc_alu (
   input  tsbc_pkg::alu_req_type req,
   output tsbc_pkg::alu_rsp_type rsp
);
   import tsbc_pkg::*;

   logic [VALUE_WIDTH-1:0] v;

   always_comb begin
      v        = req.a[VALUE_WIDTH-1:0];
      rsp.r    = req.a;
      rsp.flag = 1'b0;
      unique case (req.fn)
         ALU_GE: begin
            rsp.flag = req.a >= req.b;
         end
         ALU_SAT_INC: begin
            if (v != {VALUE_WIDTH{1'b1}}) begin
               rsp.r = ALU_W'(v + VALUE_WIDTH'(1));
            end else begin
               rsp.r = ALU_W'(v);
            end
         end
         ALU_SAT_DEC: begin
            if (v != '0) begin
               rsp.r = ALU_W'(v - VALUE_WIDTH'(1));
            end else begin
               rsp.r = ALU_W'(v);
            end
         end
         default: begin
            rsp.r = req.a;
         end
      endcase
   end
endmodule
`default_nettype wire

@@ verif/tagged_stack_bytecode_core_test.sv @@
// Self-checking testbench for tagged_stack_bytecode_core: directed table then random programs,
// each rsp word checked against an in-bench model of the stacks. Depends on tsbc_pkg and the RTL.
`timescale 1ns / 1ps
module tagged_stack_bytecode_core_test;
   import tsbc_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 300;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_word;
   logic         csr_write_enable;
   logic [31:0]  csr_write_data;

   tagged_stack_bytecode_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---- machine model: mirrors the core's architectural state ----
   logic [VALUE_WIDTH:0]   vstack [VALUE_DEPTH];   // tag in top bit
   logic [31:0]            astack [ARG_DEPTH];
   logic [LINE_WIDTH-1:0]  fline  [FRAME_DEPTH];
   int unsigned            fcount [FRAME_DEPTH];
   int unsigned            vtop, atop, ftop;
   logic [LINE_WIDTH-1:0]  line_now;
   logic [31:0]            steps_done;
   logic [31:0]            step_limit;

   rsp_word_type expected_words [$];
   int  failures;
   bit  stimulus_done;
   int  idle_cycles;
   int  send_idle_pct, recv_idle_pct;

   localparam logic [VALUE_WIDTH:0] TAG = {1'b1, {VALUE_WIDTH{1'b0}}};
   localparam logic [VALUE_WIDTH-1:0] VMAX = '1;

   function automatic void clear_machine();
      vtop = 0; atop = 0; ftop = 0; line_now = '0; steps_done = '0;
   endfunction

   // executes one instruction on the model and returns the word the core should give
   function automatic rsp_word_type execute_instruction(req_word_type w);
      rsp_word_type r;
      logic [LINE_WIDTH-1:0] nxt;
      logic [VALUE_WIDTH-1:0] v;
      logic stack_fault;
      int unsigned d, idx;
      bit found;
      nxt = line_now + 1'b1;
      stack_fault = 1'b0;
      r = '0;
      if (w.halt_request) begin
         if (vtop == 0) stack_fault = 1'b1;
         else begin
            r.halted = 1'b1;
            r.result_value = vstack[vtop-1][VALUE_WIDTH-1:0];
         end
      end else begin
         case (w.op)
            OP_POPJZ: if (vtop == 0) stack_fault = 1'b1;
               else begin
                  vtop--;
                  if (vstack[vtop] == '0) nxt = w.argument[LINE_WIDTH-1:0];
               end
            OP_DEC, OP_INC: if (w.argument >= vtop) stack_fault = 1'b1;
               else begin
                  idx = vtop - 1 - w.argument;
                  v = vstack[idx][VALUE_WIDTH-1:0];
                  if (w.op == OP_INC) begin
                     if (v != VMAX) v++;
                  end else if (v != 0) v--;
                  vstack[idx] = {vstack[idx][VALUE_WIDTH], v};
               end
            OP_CONST, OP_MARK: if (vtop >= VALUE_DEPTH) stack_fault = 1'b1;
               else begin
                  vstack[vtop] = (w.op == OP_CONST) ? {1'b0, w.argument[VALUE_WIDTH-1:0]}
                                : (TAG | w.argument[LINE_WIDTH-1:0]);
                  vtop++;
               end
            OP_JNZ: if (vtop == 0) stack_fault = 1'b1;
               else if (vstack[vtop-1] != '0) nxt = w.argument[LINE_WIDTH-1:0];
            OP_COPY: if (w.argument >= vtop || vtop >= VALUE_DEPTH) stack_fault = 1'b1;
               else begin
                  vstack[vtop] = vstack[vtop-1-w.argument];
                  vtop++;
               end
            OP_LOAD: if (w.argument >= atop || vtop >= VALUE_DEPTH) stack_fault = 1'b1;
               else begin
                  vstack[vtop] = {1'b0, astack[atop-1-w.argument]};
                  vtop++;
               end
            OP_CALL: begin
               d = 0; found = 0;
               while (d < vtop && !found) begin
                  if (vstack[vtop-1-d][VALUE_WIDTH]) found = 1;
                  else d++;
               end
               if (!found || atop + d > ARG_DEPTH || ftop >= FRAME_DEPTH) stack_fault = 1'b1;
               else begin
                  repeat (d) begin
                     vtop--;
                     astack[atop] = vstack[vtop][VALUE_WIDTH-1:0];
                     atop++;
                  end
                  vtop--;
                  fline[ftop] = line_now;
                  fcount[ftop] = d;
                  ftop++;
                  nxt = vstack[vtop][LINE_WIDTH-1:0];
               end
            end
            OP_RET: if (ftop == 0 || fcount[ftop-1] > atop) stack_fault = 1'b1;
               else begin
                  ftop--;
                  atop -= fcount[ftop];
                  nxt = fline[ftop] + 1'b1;
               end
            OP_POP: if (w.argument >= vtop) stack_fault = 1'b1;
               else begin
                  for (int unsigned i = w.argument; i != 0; i--)
                     vstack[vtop-i-1] = vstack[vtop-i];
                  vtop--;
               end
            default: ;
         endcase
         if (!stack_fault) begin
            steps_done++;
            if (steps_done >= step_limit) r.fault = FAULT_STEP;
         end
      end
      if (stack_fault) r.fault = FAULT_STACK;
      if (r.halted || r.fault != FAULT_NONE) begin
         clear_machine();
         nxt = '0;
      end else line_now = nxt;
      r.next_line = nxt;
      return r;
   endfunction

   // evaluates a word on a copy of the model state without advancing it
   function automatic rsp_word_type execute_instruction_peek(req_word_type w);
      rsp_word_type r;
      logic [VALUE_WIDTH:0]  sv [VALUE_DEPTH];
      logic [31:0]           sa [ARG_DEPTH];
      logic [LINE_WIDTH-1:0] sl [FRAME_DEPTH];
      int unsigned           sc [FRAME_DEPTH];
      int unsigned           st_v, st_a, st_f;
      logic [LINE_WIDTH-1:0] s_line;
      logic [31:0]           s_steps;
      sv = vstack; sa = astack; sl = fline; sc = fcount;
      st_v = vtop; st_a = atop; st_f = ftop; s_line = line_now; s_steps = steps_done;
      r = execute_instruction(w);
      vstack = sv; astack = sa; fline = sl; fcount = sc;
      vtop = st_v; atop = st_a; ftop = st_f; line_now = s_line; steps_done = s_steps;
      return r;
   endfunction

   // ---- driving ----
   // called at a falling edge; valid stays high after the accept so that a
   // back-to-back word follows without a second assignment in one step
   task automatic send_word(req_word_type w);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_word  <= w;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_words.push_back(execute_instruction(w));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_step_limit(logic [31:0] value);
      csr_write_data   <= value;
      csr_write_enable <= 1'b1;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      step_limit = value;
   endtask

   function automatic req_word_type make_word(logic [3:0] op, logic [31:0] argument);
      req_word_type w;
      w.op = op; w.halt_request = 1'b0; w.argument = argument;
      return w;
   endfunction

   function automatic req_word_type halt_word();
      req_word_type w;
      w.op = 4'($urandom); w.halt_request = 1'b1; w.argument = $urandom;
      return w;
   endfunction

   // random instruction, biased towards arguments that are legal in the current state
   function automatic req_word_type random_instruction();
      int unsigned pick;
      logic [3:0] op;
      logic [31:0] a;
      pick = $urandom_range(99);
      if (pick < 3) return halt_word();
      if (pick < 8) begin
         op = 4'($urandom);          // includes unused codes
         a = $urandom;
      end else begin
         op = 4'($urandom_range(10));
         case ($urandom_range(5))
            0: a = $urandom;
            1: a = '1;
            default: a = (vtop > 0 && $urandom_range(9) != 0) ? $urandom_range(vtop - 1)
                                                              : $urandom_range(3);
         endcase
         if (op == OP_LOAD && atop > 0 && $urandom_range(3) != 0) a = $urandom_range(atop - 1);
         if ((op == OP_JNZ || op == OP_POPJZ || op == OP_MARK) && $urandom_range(1))
            a = {16'($urandom_range(65535)), 16'($urandom)}
                ^ {16'h0, 16'($urandom_range(31))};
         if (op == OP_CONST) a = ($urandom_range(3) == 0) ? '1 : $urandom;
      end
      return make_word(op, a);
   endfunction

   // ---- checking ----
   initial begin
      failures = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $error("rsp word with nothing expected: %p", rsp_word);
               failures++;
            end else begin
               rsp_word_type e;
               e = expected_words.pop_front();
               if (rsp_word.next_line !== e.next_line) begin
                  $error("next_line expected %0d actual %0d", e.next_line, rsp_word.next_line);
                  failures++;
               end
               if (rsp_word.halted !== e.halted) begin
                  $error("halted expected %0b actual %0b", e.halted, rsp_word.halted);
                  failures++;
               end
               if (rsp_word.result_value !== e.result_value) begin
                  $error("result_value expected %h actual %h", e.result_value,
                     rsp_word.result_value);
                  failures++;
               end
               if (rsp_word.fault !== e.fault) begin
                  $error("fault expected %0d actual %0d", e.fault, rsp_word.fault);
                  failures++;
               end
            end
         end
      end
   end

   // receiver stall, redrawn each falling edge
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= (recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
      end
   end

   // watchdog: cycles in which no word moved on either channel
   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
            idle_cycles = 0;
         else if (!stimulus_done) idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // directed table: word plus an optional typed expectation
   typedef struct {
      req_word_type w;
      bit           typed;
      rsp_word_type r;
   } directed_row_type;

   function automatic directed_row_type row(logic [3:0] op, bit h, logic [31:0] a,
                                            bit typed = 0, logic [15:0] nl = 0,
                                            bit hl = 0, logic [31:0] rv = 0,
                                            logic [1:0] f = FAULT_NONE);
      directed_row_type x;
      x.w.op = op; x.w.halt_request = h; x.w.argument = a;
      x.typed = typed;
      x.r.next_line = nl; x.r.halted = hl; x.r.result_value = rv; x.r.fault = f;
      return x;
   endfunction

   initial begin
      directed_row_type rows [$];
      rsp_word_type typed_word;
      int items;
      reset = 1'b1; req_valid = 1'b0; req_word = '0;
      csr_write_enable = 1'b0; csr_write_data = '0;
      send_idle_pct = 0; recv_idle_pct = 0; stimulus_done = 0;
      step_limit = MAX_STEPS_RESET;
      clear_machine();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // after reset every stack is empty: these fault at once
      rows.push_back(row(OP_POPJZ, 0, 0, 1, 0, 0, 0, FAULT_STACK));
      rows.push_back(row(4'd15, 1, '1, 1, 0, 0, 0, FAULT_STACK));   // halt on empty stack
      rows.push_back(row(OP_RET, 0, 0, 1, 0, 0, 0, FAULT_STACK));
      rows.push_back(row(OP_CONST, 0, '1, 1, 1, 0, 0, FAULT_NONE));
      rows.push_back(row(4'd0, 1, 0, 1, 0, 1, 32'hffff_ffff, FAULT_NONE));
      rows.push_back(row(OP_CONST, 0, '1));
      rows.push_back(row(OP_INC, 0, 0));                 // saturates at max
      rows.push_back(row(OP_CONST, 0, 0));
      rows.push_back(row(OP_DEC, 0, 0));                 // saturates at zero
      rows.push_back(row(OP_JNZ, 0, 32'hffff_0007));
      rows.push_back(row(OP_POPJZ, 0, 32'h0001_0005));
      rows.push_back(row(OP_MARK, 0, 32'hdead_0040));
      rows.push_back(row(OP_CONST, 0, 32'h1234_5678));
      rows.push_back(row(OP_CONST, 0, 32'h8000_0001));
      rows.push_back(row(OP_COPY, 0, 2));                // copies the marker
      rows.push_back(row(OP_INC, 0, 0));                 // marker keeps its tag
      rows.push_back(row(OP_JNZ, 0, 32'h0000_0011));     // marker counts as nonzero
      rows.push_back(row(OP_POP, 0, 0));
      rows.push_back(row(OP_CALL, 0, 0));
      rows.push_back(row(OP_LOAD, 0, 1));
      rows.push_back(row(OP_POP, 0, 1));
      rows.push_back(row(4'd12, 0, 0));                  // unused op only advances
      rows.push_back(row(OP_RET, 0, 0));
      rows.push_back(row(OP_COPY, 0, '1));               // depth far past the top
      rows.push_back(row(OP_CALL, 0, 0));                // no marker

      foreach (rows[i]) begin
         typed_word = execute_instruction_peek(rows[i].w);
         if (rows[i].typed && typed_word !== rows[i].r) begin
            $error("table row %0d: model gives %p, table %p", i, typed_word, rows[i].r);
            failures++;
         end
         send_word(rows[i].w);
      end
      wait_drained();

      // random part in phases of idling and step limit
      items = 0;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase % 3)
            0: begin send_idle_pct = 27; recv_idle_pct = 75; end
            1: begin send_idle_pct = 75; recv_idle_pct = 27; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         case (phase)
            0: write_step_limit(32'hffff_ffff);
            1: write_step_limit(1);
            2: write_step_limit(32'd7);
            3: write_step_limit(32'd40);
            4: write_step_limit(MAX_STEPS_RESET);
            default: write_step_limit($urandom_range(60, 5));
         endcase
         repeat (phase == 1 ? 40 : 105) begin
            // occasional long call/return program: mark, args, call, a load, return
            if ($urandom_range(9) == 0 && vtop < VALUE_DEPTH - 8) begin
               send_word(make_word(OP_MARK,
                  32'(line_now + 16'd3 + 16'($urandom_range(2)))));
               repeat ($urandom_range(4)) send_word(make_word(OP_CONST, $urandom));
               send_word(make_word(OP_CALL, $urandom_range(3)));
               if (atop > 0) send_word(make_word(OP_LOAD, $urandom_range(atop - 1)));
               send_word(make_word(OP_RET, $urandom));
               items += 6;
            end else begin
               send_word(random_instruction());
               items++;
            end
         end
         wait_drained();
      end

      stimulus_done = 1;
      if (failures == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end
endmodule
